>>> sv/tts_pkg.sv
package tts_pkg;

    // design constants
    localparam int CAL_SAMPLES  = 50;
    localparam int SAMPLE_BITS  = 10;

    // fixed field widths
    localparam int SAMPLE_IN_W  = 10;
    localparam int AXIS_W       = 2;
    localparam int DB_W         = 10;
    localparam int GAIN_W       = 6;
    localparam int WIDTH_W      = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    // derived widths
    localparam int SAMPLE_EXT_W = SAMPLE_IN_W + SAMPLE_BITS;
    localparam int COUNT_W      = $clog2(CAL_SAMPLES + 1);
    localparam int SUM_W        = SAMPLE_BITS + $clog2(CAL_SAMPLES);
    localparam int CMP_W        = (SAMPLE_BITS > DB_W ? SAMPLE_BITS : DB_W) + 2;
    localparam int PROD_W       = SAMPLE_BITS + GAIN_W;
    localparam int WSUM_W       = (PROD_W > WIDTH_W ? PROD_W : WIDTH_W) + 1;

    // sum / CAL_SAMPLES as a multiply by a rounded-up reciprocal and a shift
    localparam int DIV_SHIFT    = SUM_W + $clog2(CAL_SAMPLES);
    localparam int DIV_MULT_W   = DIV_SHIFT + 1;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));
    localparam int QPROD_W      = SUM_W + DIV_MULT_W;

    // register reset values
    localparam logic [DB_W-1:0]    DEADBAND_RST     = DB_W'(10);
    localparam logic [GAIN_W-1:0]  GAIN_RST         = GAIN_W'(9);
    localparam logic [WIDTH_W-1:0] CENTER_WIDTH_RST = WIDTH_W'(1500);
    localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST    = WIDTH_W'(500);
    localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST    = WIDTH_W'(2500);
    localparam logic [WIDTH_W-1:0] FRAME_LENGTH_RST = WIDTH_W'(20000);

    // axis codes
    localparam logic [AXIS_W-1:0] AXIS_X    = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND     = 3'd0,
        CFG_GAIN         = 3'd1,
        CFG_CENTER_WIDTH = 3'd2,
        CFG_MIN_WIDTH    = 3'd3,
        CFG_MAX_WIDTH    = 3'd4,
        CFG_FRAME_LENGTH = 3'd5
    } cfg_reg_t;

endpackage

>>> sv/tilt_to_dual_servo_pwm.sv
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+---------------------------------------------
// input    | in        | in_valid, in_stall | opcode, axis, sample
// output   | out       | out_valid, out_stall | servo1/2_level, servo1/2_width,
//          |           |                    | calibrated, frame_start
// config   | in        | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// one transaction per cycle sustained while the output is not stalled; path from input to result:
// (input register, then one pass of compare/multiply/add into the result register)
// the zero-point divide is a constant reciprocal multiply in the same pass
// reset loads register defaults, centers both widths, clears calibration and frame counter
// a stalled output holds the result; the input register still takes one more transaction
// cfg_ready is always high
module tilt_to_dual_servo_pwm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          opcode,
    input  logic [tts_pkg::AXIS_W-1:0]    axis,
    input  logic [tts_pkg::SAMPLE_IN_W-1:0] sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          servo1_level,
    output logic                          servo2_level,
    output logic [tts_pkg::WIDTH_W-1:0]   servo1_width,
    output logic [tts_pkg::WIDTH_W-1:0]   servo2_width,
    output logic                          calibrated,
    output logic                          frame_start,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tts_pkg::*;

    // configuration registers
    logic [DB_W-1:0]    deadband_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [WIDTH_W-1:0] center_reg;
    logic [WIDTH_W-1:0] min_reg;
    logic [WIDTH_W-1:0] max_reg;
    logic [WIDTH_W-1:0] frame_len_reg;

    // input register
    logic                   in_vld_reg;
    op_t                    op_reg;
    logic [AXIS_W-1:0]      axis_reg;
    logic [SAMPLE_BITS-1:0] samp_reg;

    // block state
    logic [WIDTH_W-1:0]     width1_reg, width1_next;
    logic [WIDTH_W-1:0]     width2_reg, width2_next;
    logic [SAMPLE_BITS-1:0] zero_reg [3];
    logic [SAMPLE_BITS-1:0] zero_next [3];
    logic [SUM_W-1:0]       sum_reg [3];
    logic [SUM_W-1:0]       sum_next [3];
    logic [COUNT_W-1:0]     cnt_reg [3];
    logic [COUNT_W-1:0]     cnt_next [3];
    logic [WIDTH_W-1:0]     fc_reg, fc_next;

    // result register
    logic                   out_vld_reg;
    logic                   l1_reg, l1_next;
    logic                   l2_reg, l2_next;
    logic                   cal_reg, cal_next;
    logic                   fs_reg, fs_next;

    logic                   advance;
    logic                   in_accept;
    logic [SAMPLE_BITS-1:0] samp_in;

    // datapath intermediates
    logic [SAMPLE_BITS-1:0] zero_sel;
    logic [SUM_W-1:0]       sum_sel;
    logic [COUNT_W-1:0]     cnt_sel;
    logic [SUM_W-1:0]       sum_new;
    logic [QPROD_W-1:0]     quot_prod;
    logic signed [CMP_W-1:0] off_s;
    logic signed [CMP_W-1:0] db_s;
    logic [SAMPLE_BITS-1:0] mag;
    logic [PROD_W-1:0]      prod;
    logic [WSUM_W-1:0]      up_sum;
    logic [WSUM_W-1:0]      dn_diff;
    logic [WIDTH_W-1:0]     up_w;
    logic [WIDTH_W-1:0]     dn_w;
    logic [WIDTH_W-1:0]     new_w;
    logic [WIDTH_W-1:0]     len;
    logic [WIDTH_W:0]       fc_inc;

    // handshake
    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign samp_in   = SAMPLE_BITS'(SAMPLE_EXT_W'(sample));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            gain_reg      <= GAIN_RST;
            center_reg    <= CENTER_WIDTH_RST;
            min_reg       <= MIN_WIDTH_RST;
            max_reg       <= MAX_WIDTH_RST;
            frame_len_reg <= FRAME_LENGTH_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_DEADBAND:     deadband_reg  <= DB_W'(cfg_data);
                CFG_GAIN:         gain_reg      <= GAIN_W'(cfg_data);
                CFG_CENTER_WIDTH: center_reg    <= cfg_data;
                CFG_MIN_WIDTH:    min_reg       <= cfg_data;
                CFG_MAX_WIDTH:    max_reg       <= cfg_data;
                CFG_FRAME_LENGTH: frame_len_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // selected axis state
    always_comb
    begin
        zero_sel = zero_reg[axis_reg];
        sum_sel  = sum_reg[axis_reg];
        cnt_sel  = cnt_reg[axis_reg];
    end

    // calibration sum and zero point by reciprocal multiply
    assign sum_new   = sum_sel + SUM_W'(samp_reg);
    assign quot_prod = QPROD_W'(sum_new) * QPROD_W'(DIV_MULT);

    // offset from zero point and deadband, signed
    assign off_s = $signed(CMP_W'(samp_reg)) - $signed(CMP_W'(zero_sel));
    assign db_s  = $signed(CMP_W'(deadband_reg));
    assign mag   = SAMPLE_BITS'(off_s[CMP_W-1] ? -off_s : off_s);
    assign prod  = PROD_W'(gain_reg) * PROD_W'(mag);

    // high side clamps at max, low side at min including underflow
    assign up_sum  = WSUM_W'(center_reg) + WSUM_W'(prod);
    assign dn_diff = WSUM_W'(center_reg) - WSUM_W'(prod);

    always_comb
    begin
        if (up_sum > WSUM_W'(max_reg))
        begin
            up_w = max_reg;
        end
        else
        begin
            up_w = WIDTH_W'(up_sum);
        end

        if (WSUM_W'(prod) > WSUM_W'(center_reg))
        begin
            dn_w = min_reg;
        end
        else if (WIDTH_W'(dn_diff) < min_reg)
        begin
            dn_w = min_reg;
        end
        else
        begin
            dn_w = WIDTH_W'(dn_diff);
        end

        priority if (off_s > db_s)
        begin
            new_w = up_w;
        end
        else if (off_s < -db_s)
        begin
            new_w = dn_w;
        end
        else
        begin
            new_w = center_reg;
        end
    end

    // frame counter step
    assign len    = (frame_len_reg == '0) ? WIDTH_W'(1) : frame_len_reg;
    assign fc_inc = (WIDTH_W + 1)'(fc_reg) + (WIDTH_W + 1)'(1);

    // next state and result for the item in the input register
    always_comb
    begin
        width1_next = width1_reg;
        width2_next = width2_reg;
        zero_next   = zero_reg;
        sum_next    = sum_reg;
        cnt_next    = cnt_reg;
        fc_next     = fc_reg;
        l1_next     = 1'b0;
        l2_next     = 1'b0;
        fs_next     = 1'b0;

        if (op_reg == OP_TICK)
        begin
            fs_next = (fc_reg == '0);
            l1_next = (fc_reg < width1_reg);
            l2_next = (fc_reg < width2_reg);
            if (fc_inc >= (WIDTH_W + 1)'(len))
            begin
                fc_next = '0;
            end
            else
            begin
                fc_next = WIDTH_W'(fc_inc);
            end
        end
        else if (axis_reg != AXIS_NONE)
        begin
            if (cnt_sel < COUNT_W'(CAL_SAMPLES))
            begin
                sum_next[axis_reg] = sum_new;
                cnt_next[axis_reg] = cnt_sel + COUNT_W'(1);
                if (cnt_sel == COUNT_W'(CAL_SAMPLES - 1))
                begin
                    zero_next[axis_reg] = quot_prod[DIV_SHIFT +: SAMPLE_BITS];
                end
            end
            else if (axis_reg == AXIS_X)
            begin
                width1_next = new_w;
            end
            else if (axis_reg == AXIS_Y)
            begin
                width2_next = new_w;
            end
        end

        cal_next = (cnt_next[AXIS_X] == COUNT_W'(CAL_SAMPLES)) &&
                   (cnt_next[AXIS_Y] == COUNT_W'(CAL_SAMPLES)) &&
                   (cnt_next[AXIS_Z] == COUNT_W'(CAL_SAMPLES));
    end

    // control and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            width1_reg  <= CENTER_WIDTH_RST;
            width2_reg  <= CENTER_WIDTH_RST;
            zero_reg    <= '{default: '0};
            sum_reg     <= '{default: '0};
            cnt_reg     <= '{default: '0};
            fc_reg      <= '0;
            cal_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_vld_reg && !out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                width1_reg <= width1_next;
                width2_reg <= width2_next;
                zero_reg   <= zero_next;
                sum_reg    <= sum_next;
                cnt_reg    <= cnt_next;
                fc_reg     <= fc_next;
                cal_reg    <= cal_next;
            end
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op_t'(opcode);
            axis_reg <= axis;
            samp_reg <= samp_in;
        end
        if (advance)
        begin
            l1_reg <= l1_next;
            l2_reg <= l2_next;
            fs_reg <= fs_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign servo1_level = l1_reg;
    assign servo2_level = l2_reg;
    assign servo1_width = width1_reg;
    assign servo2_width = width2_reg;
    assign calibrated   = cal_reg;
    assign frame_start  = fs_reg;

`ifndef NO_ASSERTIONS
    // calibration counts saturate at the sample count
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= COUNT_W'(CAL_SAMPLES) && cnt_reg[1] <= COUNT_W'(CAL_SAMPLES) &&
        cnt_reg[2] <= COUNT_W'(CAL_SAMPLES))
        else $error("calibration count beyond limit");

    // calibrated flag never drops once set
    a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(cal_reg))
        else $error("calibrated flag dropped");

    // a stall toward the input only comes from a full input register
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled without a blocked result");

    // an item moved forward always shows up as a result
    a_adv_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advanced item lost");

    // frame counter only moves on a tick leaving the input register
    a_fc_tick: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && op_reg == OP_TICK) |=> $stable(fc_reg))
        else $error("frame counter moved without a tick");
`endif

endmodule
